FILE: design/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/rtswb_pkg.sv
// ----------------------------------------------------------------------------
// rtswb_pkg
// Shared constants, codes and control types of the send window buffer.
// ----------------------------------------------------------------------------
package rtswb_pkg;

   // Ring depth in bytes; a power of two so a position maps to a slot by its low bits.
   localparam int DEPTH  = 4096;
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int POS_W  = 32;
   localparam int KIND_W = 3;

   localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_FETCH  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ACK    = 3'd2;
   localparam logic [KIND_W-1:0] KIND_INIT   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESEND = 3'd4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOAD,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic load;
   } ctrl_cmd_type;

endpackage

FILE: design/rtswb_ctrl.sv
// ----------------------------------------------------------------------------
// rtswb_ctrl
// Sequencer: takes one word, runs the update, loads the result, hands it out.
// ----------------------------------------------------------------------------
module rtswb_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output rtswb_pkg::ctrl_cmd_type cmd
);

   rtswb_pkg::state_type state_ff;
   rtswb_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rtswb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rtswb_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = rtswb_pkg::ST_EXEC;
         end
         rtswb_pkg::ST_EXEC: state_in = rtswb_pkg::ST_LOAD;
         rtswb_pkg::ST_LOAD: state_in = rtswb_pkg::ST_RESP;
         rtswb_pkg::ST_RESP: begin
            if (rsp_tready) state_in = rtswb_pkg::ST_IDLE;
         end
         default: state_in = rtswb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         rtswb_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         rtswb_pkg::ST_EXEC: cmd.execute = 1'b1;
         rtswb_pkg::ST_LOAD: cmd.load    = 1'b1;
         rtswb_pkg::ST_RESP: rsp_tvalid  = 1'b1;
         default: ;
      endcase
   end

endmodule

FILE: design/rtswb_dpath.sv
// ----------------------------------------------------------------------------
// rtswb_dpath
// Position registers, byte ring and result register.
// ----------------------------------------------------------------------------
module rtswb_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  rtswb_pkg::ctrl_cmd_type         cmd,
   input  logic [rtswb_pkg::KIND_W-1:0]    in_kind,
   input  logic [7:0]                      in_data_byte,
   input  logic [rtswb_pkg::POS_W-1:0]     in_position_value,
   output logic                            out_accepted,
   output logic [7:0]                      out_byte,
   output logic [rtswb_pkg::POS_W-1:0]     out_acked_position,
   output logic [rtswb_pkg::POS_W-1:0]     out_send_position,
   output logic                            out_pending_to_send,
   output logic                            out_unacknowledged
);

   localparam int SW = rtswb_pkg::SLOT_W;
   localparam int PW = rtswb_pkg::POS_W;

   logic [rtswb_pkg::KIND_W-1:0] kind_ff;
   logic [7:0]                   data_ff;
   logic [PW-1:0]                value_ff;

   logic [PW-1:0] ack_ff,  ack_in;
   logic [PW-1:0] send_ff, send_in;
   logic [PW-1:0] end_ff,  end_in;
   logic          acc_ff;
   logic [7:0]    rd_ff;

   logic [7:0]    store_mem [rtswb_pkg::DEPTH];

   logic [PW-1:0] span;
   logic          write_ok;
   logic          fetch_ok;

   logic          res_acc_ff;
   logic [7:0]    res_byte_ff;
   logic [PW-1:0] res_ack_ff;
   logic [PW-1:0] res_send_ff;
   logic          res_pend_ff;
   logic          res_unack_ff;

   // hold the accepted word
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= in_kind;
         data_ff  <= in_data_byte;
         value_ff <= in_position_value;
      end
   end

   assign span     = end_ff - ack_ff;
   assign write_ok = (kind_ff == rtswb_pkg::KIND_WRITE) && (span < PW'(rtswb_pkg::DEPTH));
   assign fetch_ok = (kind_ff == rtswb_pkg::KIND_FETCH) && (end_ff != send_ff);

   always_comb begin
      ack_in  = ack_ff;
      send_in = send_ff;
      end_in  = end_ff;
      unique case (kind_ff)
         rtswb_pkg::KIND_WRITE: begin
            if (write_ok) end_in = end_ff + PW'(1);
         end
         rtswb_pkg::KIND_FETCH: begin
            if (fetch_ok) send_in = send_ff + PW'(1);
         end
         rtswb_pkg::KIND_ACK: ack_in = value_ff;
         rtswb_pkg::KIND_INIT: begin
            ack_in  = value_ff;
            send_in = value_ff;
            end_in  = value_ff;
         end
         rtswb_pkg::KIND_RESEND: send_in = ack_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_ff  <= '0;
         send_ff <= '0;
         end_ff  <= '0;
      end else if (cmd.execute) begin
         ack_ff  <= ack_in;
         send_ff <= send_in;
         end_ff  <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) acc_ff <= write_ok || fetch_ok;
   end

   // ring: write at the end slot, read the send slot before it advances
   always_ff @(posedge clock) begin
      if (cmd.execute && write_ok) store_mem[end_ff[SW-1:0]] <= data_ff;
      if (cmd.execute) rd_ff <= store_mem[send_ff[SW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         res_acc_ff   <= acc_ff;
         res_byte_ff  <= (acc_ff && (kind_ff == rtswb_pkg::KIND_FETCH)) ? rd_ff : 8'd0;
         res_ack_ff   <= ack_ff;
         res_send_ff  <= send_ff;
         res_pend_ff  <= (end_ff != send_ff);
         res_unack_ff <= (send_ff != ack_ff);
      end
   end

   assign out_accepted        = res_acc_ff;
   assign out_byte            = res_byte_ff;
   assign out_acked_position  = res_ack_ff;
   assign out_send_position   = res_send_ff;
   assign out_pending_to_send = res_pend_ff;
   assign out_unacknowledged  = res_unack_ff;

endmodule

FILE: design/retransmit_send_window_buffer_top.sv
// The result is offered after the update and load states that follow the edge that accepts the word.
// The block takes one word at a time and holds it until its result is handed out.
// The result waits in its output register; no new word is taken until it leaves.
// The word rate is set by the sequencer: capture, update with ring access, load, hand out.
// Reset (synchronous, active high) zeroes the three positions; ring content is undefined.
// ----------------------------------------------------------------------------
// retransmit_send_window_buffer_top
// Byte ring for a reliable sender with acked, send and end positions.
// ----------------------------------------------------------------------------
module retransmit_send_window_buffer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // data_byte[7:0], position_value[39:8]
   input  logic [2:0]  req_tuser,   // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // out_byte[7:0], acked_position[39:8],
                                    // send_position[71:40], pending_to_send[72],
                                    // unacknowledged[73], zero[79:74]
   output logic [0:0]  rsp_tuser    // accepted[0]
);

   rtswb_pkg::ctrl_cmd_type cmd;

   logic        accepted;
   logic [7:0]  out_byte;
   logic [31:0] acked_position;
   logic [31:0] send_position;
   logic        pending_to_send;
   logic        unacknowledged;

   rtswb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   rtswb_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .in_kind             (req_tuser),
      .in_data_byte        (req_tdata[7:0]),
      .in_position_value   (req_tdata[39:8]),
      .out_accepted        (accepted),
      .out_byte            (out_byte),
      .out_acked_position  (acked_position),
      .out_send_position   (send_position),
      .out_pending_to_send (pending_to_send),
      .out_unacknowledged  (unacknowledged)
   );

   assign rsp_tdata = {6'd0, unacknowledged, pending_to_send, send_position,
                       acked_position, out_byte};
   assign rsp_tuser = accepted;

endmodule

FILE: design/rtswb_checker.sv
// ----------------------------------------------------------------------------
// rtswb_checker
// Port-level checks of the send window buffer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtswb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   logic        req_fire;
   logic        rsp_wait;
   logic        rsp_reject;
   logic        byte_zero;
   logic        unack_ok;
   logic [80:0] rsp_word;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_wait   = rsp_tvalid && !rsp_tready;
   assign rsp_reject = rsp_tvalid && !rsp_tuser[0];
   assign byte_zero  = (rsp_tdata[7:0] == 8'd0);
   assign unack_ok   = (rsp_tdata[73] == (rsp_tdata[71:40] != rsp_tdata[39:8]));
   assign rsp_word   = {rsp_tuser, rsp_tdata};

   `ASSERT_NEXT(a_no_early_rsp, clock, reset, req_fire, !rsp_tvalid, "result too early")
   `ASSERT_IMPL(a_one_in_flight, clock, reset, rsp_tvalid, !req_tready, "ready while busy")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_tvalid && $stable(rsp_word), "result moved")
   `ASSERT_IMPL(a_byte_zero, clock, reset, rsp_reject, byte_zero, "byte set without accept")
   `ASSERT_IMPL(a_unack_flag, clock, reset, rsp_tvalid, unack_ok, "unacked flag mismatch")

endmodule

bind retransmit_send_window_buffer_top rtswb_checker u_rtswb_checker (.*);
